>>> hdl/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
package ffsa_pkg;

   // Status codes reported with every result item.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_BADSIZE = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Allocation size limits and header rounding.
   localparam logic [19:0] MAX_BYTES   = 20'hffff0;
   localparam logic [20:0] HDR_ROUND   = 21'd21;
   localparam logic [16:0] HEAP_END    = 17'h10000;

   // One free extent as it sits in the extent memory.
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] len;
   } extent_type;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_DECIDE  = 7'b0000100,
      S_SHIFT   = 7'b0001000,
      S_PLACE   = 7'b0010000,
      S_LARGEST = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

endpackage

>>> hdl/ffsa_ext_mem.sv
// Extent memory: one write port and one registered read port.
module ffsa_ext_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  ffsa_pkg::extent_type  wr_data,
   input  logic [AW-1:0]         rd_addr,
   output ffsa_pkg::extent_type  rd_data
);

   ffsa_pkg::extent_type mem [DEPTH];
   ffsa_pkg::extent_type rd_data_ff;

   // Write and read both happen on the clock; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator with free-extent coalescing.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  req     | in        | req_valid/req_stall| req_type, alloc_bytes, free_segment/paragraphs
//  rsp     | out       | rsp_valid/rsp_stall| status, block_*, total/largest_free, blocks
//
// One item passes, in order, through the accept cycle, a search walk that stops
// at the first fitting or following extent, a decide step, a shift over the rest
// of the table, a place step for a new free extent, a walk of the updated table
// for the largest extent, and the result cycle; shift and place run only when needed.
// Reset is synchronous and empties the extent table at once (count only).
// req_stall stays high from acceptance until the result item is taken;
// a stalled result holds its value.
module first_fit_segment_allocator #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [19:0] req_alloc_bytes,
   input  logic [15:0] req_free_segment,
   input  logic [15:0] req_free_paragraphs,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_segment,
   output logic [15:0] rsp_block_paragraphs,
   output logic [16:0] rsp_total_free,
   output logic [16:0] rsp_largest_free,
   output logic [15:0] rsp_blocks_outstanding
);

   localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
   localparam logic [CW-1:0] ONE     = CW'(1);

   ffsa_pkg::state_type state_ff, state_in;
   logic               typ_ff, typ_in;
   logic [16:0]        need_ff, need_in;
   logic               bad_ff, bad_in;
   logic [15:0]        seg_ff, seg_in;
   logic [15:0]        plen_ff, plen_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [16:0]        total_ff, total_in;
   logic [15:0]        live_ff, live_in;
   logic [CW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      tag_ff, tag_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic               down_ff, down_in;
   logic               ins_ff, ins_in;
   logic               found_ff, found_in;
   logic [15:0]        hit_start_ff, hit_start_in;
   logic [16:0]        hit_len_ff, hit_len_in;
   logic [CW-1:0]      hit_idx_ff, hit_idx_in;
   logic               prev_ok_ff, prev_ok_in;
   logic [15:0]        prev_start_ff, prev_start_in;
   logic [16:0]        prev_len_ff, prev_len_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [16:0]        max_ff, max_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        oseg_ff, oseg_in;
   logic [15:0]        olen_ff, olen_in;

   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   ffsa_pkg::extent_type mem_wdata;
   ffsa_pkg::extent_type rd;

   logic [20:0] need_sum;
   logic [16:0] need_new;
   logic [16:0] f_end;
   logic [16:0] prev_end;
   logic        hit;
   logic        at_end;
   logic        bad_free;
   logic        join_prev;
   logic        join_next;

   ffsa_ext_mem #(
      .DEPTH (MAX_EXTENTS),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff[IW-1:0]),
      .rd_data (rd)
   );

   // Request decode and the shared compare and add terms.
   assign need_sum  = {1'b0, req_alloc_bytes} + ffsa_pkg::HDR_ROUND;
   assign need_new  = need_sum[20:4];
   assign f_end     = {1'b0, seg_ff} + {1'b0, plen_ff};
   assign prev_end  = {1'b0, prev_start_ff} + prev_len_ff;
   assign hit       = (typ_ff == ffsa_pkg::REQ_FREE) ? (rd.start > seg_ff)
                                                     : (rd.len >= need_ff);
   assign at_end    = (addr_ff >= cnt_ff);
   assign bad_free  = (plen_ff == 16'd0) || (f_end > ffsa_pkg::HEAP_END) ||
                      (prev_ok_ff && (prev_end > {1'b0, seg_ff})) ||
                      (found_ff && (f_end > {1'b0, hit_start_ff}));
   assign join_prev = prev_ok_ff && (prev_end == {1'b0, seg_ff});
   assign join_next = found_ff && ({1'b0, hit_start_ff} == f_end);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      typ_in        = typ_ff;
      need_in       = need_ff;
      bad_in        = bad_ff;
      seg_in        = seg_ff;
      plen_in       = plen_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      live_in       = live_ff;
      addr_in       = addr_ff;
      tag_in        = tag_ff;
      pend_in       = pend_ff;
      rem_in        = rem_ff;
      down_in       = down_ff;
      ins_in        = ins_ff;
      found_in      = found_ff;
      hit_start_in  = hit_start_ff;
      hit_len_in    = hit_len_ff;
      hit_idx_in    = hit_idx_ff;
      prev_ok_in    = prev_ok_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      pos_in        = pos_ff;
      max_in        = max_ff;
      status_in     = status_ff;
      oseg_in       = oseg_ff;
      olen_in       = olen_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;

      case (state_ff)
         ffsa_pkg::S_IDLE: begin
            if (req_valid) begin
               typ_in     = req_type;
               need_in    = need_new;
               bad_in     = (req_alloc_bytes == 20'd0) ||
                            (req_alloc_bytes > ffsa_pkg::MAX_BYTES) || need_new[16];
               seg_in     = req_free_segment;
               plen_in    = req_free_paragraphs;
               addr_in    = '0;
               pend_in    = 1'b0;
               found_in   = 1'b0;
               prev_ok_in = 1'b0;
               pos_in     = '0;
               state_in   = ffsa_pkg::S_SCAN;
            end
         end

         // Walk the table in address order until the first hit.
         ffsa_pkg::S_SCAN: begin
            if (pend_ff && hit) begin
               found_in     = 1'b1;
               hit_start_in = rd.start;
               hit_len_in   = rd.len;
               hit_idx_in   = tag_ff;
               pend_in      = 1'b0;
               state_in     = ffsa_pkg::S_DECIDE;
            end else begin
               if (pend_ff && (typ_ff == ffsa_pkg::REQ_FREE)) begin
                  prev_ok_in    = 1'b1;
                  prev_start_in = rd.start;
                  prev_len_in   = rd.len;
                  pos_in        = tag_ff + ONE;
               end
               if (!at_end) begin
                  tag_in  = addr_ff;
                  addr_in = addr_ff + ONE;
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     state_in = ffsa_pkg::S_DECIDE;
                  end
               end
            end
         end

         // Settle the outcome and make the single-entry update where one is needed.
         ffsa_pkg::S_DECIDE: begin
            addr_in  = '0;
            pend_in  = 1'b0;
            max_in   = '0;
            ins_in   = 1'b0;
            state_in = ffsa_pkg::S_LARGEST;
            if (typ_ff == ffsa_pkg::REQ_ALLOC) begin
               if (bad_ff) begin
                  status_in = ffsa_pkg::ST_BADSIZE;
                  oseg_in   = '0;
                  olen_in   = '0;
               end else if (!found_ff) begin
                  status_in = ffsa_pkg::ST_NOFIT;
                  oseg_in   = '0;
                  olen_in   = need_ff[15:0];
               end else begin
                  status_in = ffsa_pkg::ST_OK;
                  oseg_in   = hit_start_ff;
                  olen_in   = need_ff[15:0];
                  total_in  = total_ff - need_ff;
                  if (live_ff != 16'hffff) begin
                     live_in = live_ff + 16'd1;
                  end
                  if (hit_len_ff == need_ff) begin
                     cnt_in   = cnt_ff - ONE;
                     rem_in   = cnt_ff - ONE - hit_idx_ff;
                     addr_in  = hit_idx_ff + ONE;
                     down_in  = 1'b1;
                     state_in = ffsa_pkg::S_SHIFT;
                  end else begin
                     mem_we          = 1'b1;
                     mem_waddr       = hit_idx_ff[IW-1:0];
                     mem_wdata.start = hit_start_ff + need_ff[15:0];
                     mem_wdata.len   = hit_len_ff - need_ff;
                  end
               end
            end else begin
               oseg_in = seg_ff;
               olen_in = plen_ff;
               if (bad_free) begin
                  status_in = ffsa_pkg::ST_BADSIZE;
               end else if (!join_prev && !join_next && (cnt_ff >= CNT_MAX)) begin
                  status_in = ffsa_pkg::ST_FULL;
               end else begin
                  status_in = ffsa_pkg::ST_OK;
                  total_in  = total_ff + {1'b0, plen_ff};
                  if (live_ff != 16'd0) begin
                     live_in = live_ff - 16'd1;
                  end
                  if (join_prev) begin
                     mem_we          = 1'b1;
                     mem_waddr       = IW'(pos_ff - ONE);
                     mem_wdata.start = prev_start_ff;
                     mem_wdata.len   = prev_len_ff + {1'b0, plen_ff} +
                                       (join_next ? hit_len_ff : 17'd0);
                     if (join_next) begin
                        cnt_in   = cnt_ff - ONE;
                        rem_in   = cnt_ff - ONE - pos_ff;
                        addr_in  = pos_ff + ONE;
                        down_in  = 1'b1;
                        state_in = ffsa_pkg::S_SHIFT;
                     end
                  end else if (join_next) begin
                     mem_we          = 1'b1;
                     mem_waddr       = pos_ff[IW-1:0];
                     mem_wdata.start = seg_ff;
                     mem_wdata.len   = hit_len_ff + {1'b0, plen_ff};
                  end else begin
                     cnt_in   = cnt_ff + ONE;
                     rem_in   = cnt_ff - pos_ff;
                     addr_in  = cnt_ff - ONE;
                     down_in  = 1'b0;
                     ins_in   = 1'b1;
                     state_in = ffsa_pkg::S_SHIFT;
                  end
               end
            end
         end

         // Move entries one place, reading each entry and writing it back in the next cycle.
         ffsa_pkg::S_SHIFT: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = down_ff ? IW'(tag_ff - ONE) : IW'(tag_ff + ONE);
               mem_wdata = rd;
            end
            if (rem_ff != '0) begin
               tag_in  = addr_ff;
               addr_in = down_ff ? (addr_ff + ONE) : (addr_ff - ONE);
               rem_in  = rem_ff - ONE;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  addr_in  = '0;
                  max_in   = '0;
                  state_in = ins_ff ? ffsa_pkg::S_PLACE : ffsa_pkg::S_LARGEST;
               end
            end
         end

         // Write the new extent into the gap opened by the shift.
         ffsa_pkg::S_PLACE: begin
            mem_we          = 1'b1;
            mem_waddr       = pos_ff[IW-1:0];
            mem_wdata.start = seg_ff;
            mem_wdata.len   = {1'b0, plen_ff};
            addr_in         = '0;
            pend_in         = 1'b0;
            max_in          = '0;
            state_in        = ffsa_pkg::S_LARGEST;
         end

         // Walk the table once more for the largest extent.
         ffsa_pkg::S_LARGEST: begin
            if (pend_ff && (rd.len > max_ff)) begin
               max_in = rd.len;
            end
            if (!at_end) begin
               addr_in = addr_ff + ONE;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ffsa_pkg::S_RESP;
               end
            end
         end

         ffsa_pkg::S_RESP: begin
            if (!rsp_stall) begin
               state_in = ffsa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ffsa_pkg::S_IDLE;
         end
      endcase
   end

   // Registers; only control state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::S_IDLE;
         cnt_ff   <= '0;
         total_ff <= '0;
         live_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         live_ff  <= live_in;
         pend_ff  <= pend_in;
      end
      typ_ff        <= typ_in;
      need_ff       <= need_in;
      bad_ff        <= bad_in;
      seg_ff        <= seg_in;
      plen_ff       <= plen_in;
      addr_ff       <= addr_in;
      tag_ff        <= tag_in;
      rem_ff        <= rem_in;
      down_ff       <= down_in;
      ins_ff        <= ins_in;
      found_ff      <= found_in;
      hit_start_ff  <= hit_start_in;
      hit_len_ff    <= hit_len_in;
      hit_idx_ff    <= hit_idx_in;
      prev_ok_ff    <= prev_ok_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      pos_ff        <= pos_in;
      max_ff        <= max_in;
      status_ff     <= status_in;
      oseg_ff       <= oseg_in;
      olen_ff       <= olen_in;
   end

   // Port drive.
   assign req_stall              = (state_ff != ffsa_pkg::S_IDLE);
   assign rsp_valid              = (state_ff == ffsa_pkg::S_RESP);
   assign rsp_status             = status_ff;
   assign rsp_block_segment      = oseg_ff;
   assign rsp_block_paragraphs   = olen_ff;
   assign rsp_total_free         = total_ff;
   assign rsp_largest_free       = max_ff;
   assign rsp_blocks_outstanding = live_ff;

endmodule

>>> hdl/ffsa_checker.sv
// Port-level checks for the first-fit segment allocator, bound to the top level.
module ffsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_total_free,
   input logic [16:0] rsp_largest_free
);

   // An accepted item makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a second item right after an accepted one");

   // Only one item is in flight: no new item while a result is shown.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result item waits");

   // The largest extent never exceeds the total free space.
   a_largest_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_largest_free <= rsp_total_free))
      else $error("largest free extent above total free space");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result item changed");

   // No result item follows straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_total_free   (rsp_total_free),
   .rsp_largest_free (rsp_largest_free)
);
